[rtl/swh_pkg.sv]
// Package with constants, types and helpers of the split weight histogram.
package swh_pkg;

  localparam int MAX_BINS    = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_BINS);
  localparam int TOTAL_W     = 48;
  localparam int SCALE_W     = FRAC_BITS + 1;
  localparam int COUNT_W     = 11;
  localparam int SEL_W       = 10;
  localparam int CMD_W       = 2;
  localparam int POS_W       = SAMPLE_BITS + SCALE_W;
  localparam int WHOLE_W     = POS_W - FRAC_BITS;
  localparam int DATA_W      = SCALE_W;
  localparam int INDEX_W     = 2;

  localparam logic [SCALE_W-1:0] ONE_FX = SCALE_W'(1) << FRAC_BITS;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [INDEX_W-1:0] REG_LOW_SAMPLE = 2'd0;
  localparam logic [INDEX_W-1:0] REG_BIN_SCALE  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_BIN_COUNT  = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] LOW_RESET   = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [SCALE_W-1:0]     SCALE_RESET = SCALE_W'(1024);
  localparam logic [COUNT_W-1:0]     COUNT_RESET = COUNT_W'(1024);

  typedef struct packed {
    logic [CMD_W-1:0]              command;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [SEL_W-1:0]              bin_select;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] bin_total;
    logic [SEL_W-1:0]   bin_echo;
  } result_t;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  raddr;
    logic               wr_en;
    logic [ADDR_W-1:0]  waddr;
    logic [TOTAL_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
                                                 input logic [SCALE_W-1:0] weight);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, total} + (TOTAL_W + 1)'(weight);
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

endpackage

[rtl/swh_bin_ram.sv]
// Bin total memory: one write port, one read port, registered read data.
module swh_bin_ram
  import swh_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           req,
  output logic [TOTAL_W-1:0] rdata
);

  logic [TOTAL_W-1:0] mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[rtl/swh_ctrl.sv]
// Sequencer: clearing pass, bin position, read-modify-write and result register.
module swh_ctrl
  import swh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [SAMPLE_BITS-1:0] low_sample,
  input  logic [SCALE_W-1:0]        bin_scale,
  input  logic [COUNT_W-1:0]        bin_count,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output result_t                   result,
  output mem_req_t                  mem_req,
  input  logic [TOTAL_W-1:0]        mem_rdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_W1    = 3'd4;
  localparam logic [2:0] ST_W2    = 3'd5;
  localparam logic [2:0] ST_RWAIT = 3'd6;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [ADDR_W-1:0]      clr_addr;
  logic [SAMPLE_BITS-1:0] diff;
  logic [POS_W-1:0]       pos;
  logic [ADDR_W-1:0]      bin_addr;
  logic [SCALE_W-1:0]     weight1;
  logic [SCALE_W-1:0]     weight2;
  logic                   second;
  logic [CMD_W-1:0]       cmd;
  logic [SEL_W-1:0]       sel;
  logic                   oob;

  logic                   accept;
  logic                   slot_free;
  logic [SAMPLE_BITS:0]   diff_calc;
  logic [COUNT_W-1:0]     limit;
  logic [WHOLE_W-1:0]     whole;
  logic [FRAC_BITS-1:0]   frac;
  logic                   straddle;
  logic                   in_range;
  logic                   next_in_range;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;

  assign diff_calc = {item.sample_value[SAMPLE_BITS-1], item.sample_value}
                   - {low_sample[SAMPLE_BITS-1], low_sample};
  assign limit = (bin_count < COUNT_W'(MAX_BINS)) ? bin_count : COUNT_W'(MAX_BINS);
  assign whole = pos[POS_W-1:FRAC_BITS];
  assign frac  = pos[FRAC_BITS-1:0];
  assign straddle = ((SCALE_W + 1)'(frac) + (SCALE_W + 1)'(bin_scale))
                  > (SCALE_W + 1)'(ONE_FX);
  assign in_range      = (WHOLE_W + 1)'(whole) < (WHOLE_W + 1)'(limit);
  assign next_in_range = ((WHOLE_W + 1)'(whole) + (WHOLE_W + 1)'(1))
                       < (WHOLE_W + 1)'(limit);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(MAX_BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (item.command)
            CMD_ADD:   state_next = diff_calc[SAMPLE_BITS] ? ST_IDLE : ST_MUL;
            CMD_READ,
            CMD_CLEAR: state_next = ST_RWAIT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_next = ST_CHK;
      ST_CHK:   state_next = in_range ? ST_W1 : ST_IDLE;
      ST_W1:    state_next = second ? ST_W2 : ST_IDLE;
      ST_W2:    state_next = ST_IDLE;
      ST_RWAIT: state_next = slot_free ? ST_IDLE : ST_RWAIT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req = '0;
    case (state)
      ST_CLEAR: begin
        mem_req.wr_en = 1'b1;
        mem_req.waddr = clr_addr;
      end
      ST_IDLE: begin
        mem_req.rd_en = accept && (item.command == CMD_READ || item.command == CMD_CLEAR);
        mem_req.raddr = item.bin_select[ADDR_W-1:0];
      end
      ST_CHK: begin
        mem_req.rd_en = in_range;
        mem_req.raddr = whole[ADDR_W-1:0];
      end
      ST_W1: begin
        mem_req.wr_en = 1'b1;
        mem_req.waddr = bin_addr;
        mem_req.wdata = sat_add(mem_rdata, weight1);
        mem_req.rd_en = second;
        mem_req.raddr = bin_addr + ADDR_W'(1);
      end
      ST_W2: begin
        mem_req.wr_en = 1'b1;
        mem_req.waddr = bin_addr + ADDR_W'(1);
        mem_req.wdata = sat_add(mem_rdata, weight2);
      end
      ST_RWAIT: begin
        mem_req.wr_en = slot_free && (cmd == CMD_CLEAR) && !oob;
        mem_req.waddr = sel[ADDR_W-1:0];
      end
      default: mem_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_RWAIT && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= item.command;
      sel  <= item.bin_select;
      oob  <= (32'(item.bin_select) >= 32'(MAX_BINS));
      diff <= diff_calc[SAMPLE_BITS-1:0];
    end
    if (state == ST_MUL) begin
      pos <= POS_W'(diff) * POS_W'(bin_scale);
    end
    if (state == ST_CHK) begin
      bin_addr <= whole[ADDR_W-1:0];
      weight1  <= straddle ? SCALE_W'(frac) : ONE_FX;
      weight2  <= ONE_FX - SCALE_W'(frac);
      second   <= straddle && next_in_range;
    end
    if (state == ST_RWAIT && slot_free) begin
      result.bin_total <= oob ? '0 : mem_rdata;
      result.bin_echo  <= sel;
    end
  end

endmodule

[rtl/split_weight_histogram_top.sv]
// Split weight histogram: an add transaction runs through the multiply and the
// read-modify-write of one or two bins in the bin memory. A read transaction
// passes through the bin memory read register and then the result register,
// waiting while the previous result is not taken; a new transaction is taken
// after that, one at a time. Reset sets the configuration to its reset values,
// then a pass zeroes the bin memory; it takes configuration writes but no transaction.
module split_weight_histogram_top
  import swh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               write_en,
  input  logic [INDEX_W-1:0] write_index,
  input  logic [DATA_W-1:0]  write_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  logic signed [SAMPLE_BITS-1:0] low_sample;
  logic [SCALE_W-1:0]            bin_scale;
  logic [COUNT_W-1:0]            bin_count;
  mem_req_t                      mem_req;
  logic [TOTAL_W-1:0]            mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_sample <= LOW_RESET;
      bin_scale  <= SCALE_RESET;
      bin_count  <= COUNT_RESET;
    end else if (write_en) begin
      case (write_index)
        REG_LOW_SAMPLE: low_sample <= write_data[SAMPLE_BITS-1:0];
        REG_BIN_SCALE:  bin_scale  <= write_data[SCALE_W-1:0];
        REG_BIN_COUNT:  bin_count  <= write_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  swh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .low_sample   (low_sample),
    .bin_scale    (bin_scale),
    .bin_count    (bin_count),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  swh_bin_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

[verif/split_weight_histogram_checker.sv]
// Checker for the split weight histogram: tracks bins and registers, predicts and compares reads.
`timescale 1ns / 100ps
module split_weight_histogram_checker
  import swh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               write_en,
  input  logic [INDEX_W-1:0] write_index,
  input  logic [DATA_W-1:0]  write_data,
  input  logic               item_valid,
  input  logic               item_ready,
  input  item_t              item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_t            result,
  output int                 mismatches,
  output int                 pending,
  output int                 reads_checked
);

  logic [TOTAL_W-1:0]            bin_weight [MAX_BINS];
  logic signed [SAMPLE_BITS-1:0] low_edge;
  logic [SCALE_W-1:0]            scale_q;
  logic [COUNT_W-1:0]            count_q;
  result_t                       readout_q [$];
  int                            error_n = 0;
  int                            read_n  = 0;

  initial begin
    mismatches    = 0;
    pending       = 0;
    reads_checked = 0;
  end

  function automatic void credit_bin(input int idx, input logic [SCALE_W-1:0] weight);
    logic [TOTAL_W:0] sum;
    if (idx >= MAX_BINS) return;
    sum = {1'b0, bin_weight[idx]} + (TOTAL_W + 1)'(weight);
    bin_weight[idx] = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

  function automatic void place_sample(input logic signed [SAMPLE_BITS-1:0] sample);
    logic signed [SAMPLE_BITS+1:0] diff;
    logic [POS_W-1:0]              pos;
    logic [WHOLE_W-1:0]            whole;
    logic [FRAC_BITS-1:0]          frac;
    logic [COUNT_W-1:0]            limit;
    logic [SCALE_W:0]              reach;
    diff = sample - low_edge;
    if (diff < 0) return;
    limit = (count_q < MAX_BINS) ? count_q : COUNT_W'(MAX_BINS);
    pos   = POS_W'(diff[SAMPLE_BITS-1:0]) * POS_W'(scale_q);
    whole = pos[POS_W-1:FRAC_BITS];
    frac  = pos[FRAC_BITS-1:0];
    if (whole >= limit) return;
    reach = (SCALE_W + 1)'(frac) + (SCALE_W + 1)'(scale_q);
    if (reach > (SCALE_W + 1)'(ONE_FX)) begin
      credit_bin(int'(whole), SCALE_W'(frac));
      if (whole + 1 < limit) credit_bin(int'(whole) + 1, ONE_FX - SCALE_W'(frac));
    end else begin
      credit_bin(int'(whole), ONE_FX);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_BINS; i++) bin_weight[i] = '0;
      low_edge = 16'sh8000;
      scale_q  = SCALE_W'(1024);
      count_q  = COUNT_W'(1024);
      readout_q.delete();
    end else begin
      if (write_en) begin
        case (write_index)
          REG_LOW_SAMPLE: low_edge = write_data[SAMPLE_BITS-1:0];
          REG_BIN_SCALE:  scale_q  = write_data[SCALE_W-1:0];
          REG_BIN_COUNT:  count_q  = write_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (readout_q.size() == 0) begin
          error_n++;
          $display("%0t: unexpected result: actual total %0d bin %0d",
                   $time, result.bin_total, result.bin_echo);
        end else begin
          want = readout_q.pop_front();
          read_n++;
          if (result.bin_total !== want.bin_total) begin
            error_n++;
            $display("%0t: bin_total mismatch: expected %0d actual %0d",
                     $time, want.bin_total, result.bin_total);
          end
          if (result.bin_echo !== want.bin_echo) begin
            error_n++;
            $display("%0t: bin_echo mismatch: expected %0d actual %0d",
                     $time, want.bin_echo, result.bin_echo);
          end
        end
      end
      if (item_valid && item_ready) begin
        case (item.command)
          CMD_ADD: place_sample(item.sample_value);
          CMD_READ, CMD_CLEAR: begin
            want.bin_total = bin_weight[item.bin_select];
            want.bin_echo  = item.bin_select;
            readout_q.push_back(want);
            if (item.command == CMD_CLEAR) bin_weight[item.bin_select] = '0;
          end
          default: ;
        endcase
      end
    end
    mismatches    <= error_n;
    pending       <= readout_q.size();
    reads_checked <= read_n;
  end

endmodule

[verif/split_weight_histogram_top_test.sv]
// Testbench top for the split weight histogram: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module split_weight_histogram_top_test;
  import swh_pkg::*;

  localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
  localparam logic [INDEX_W-1:0] REG_UNUSED    = 2'd3;
  localparam int                 STALL_LIMIT   = 4000;
  localparam int                 SETTLE_CYCLES = 16;
  localparam int                 PHASES        = 8;
  localparam int                 PHASE_ITEMS   = 150;
  localparam int                 HOLD_CYCLES   = 300;

  logic               clk;
  logic               rst;
  logic               write_en;
  logic [INDEX_W-1:0] write_index;
  logic [DATA_W-1:0]  write_data;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  logic               result_valid;
  logic               result_ready;
  result_t            result;

  int mismatches;
  int pending;
  int reads_checked;
  int idle_n;
  int sent_n     = 0;
  int settings_n = 0;
  int cur_low;
  int cur_scale;
  int cur_count;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  split_weight_histogram_top dut (
    .clk          (clk),
    .rst          (rst),
    .write_en     (write_en),
    .write_index  (write_index),
    .write_data   (write_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  split_weight_histogram_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .write_en      (write_en),
    .write_index   (write_index),
    .write_data    (write_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .mismatches    (mismatches),
    .pending       (pending),
    .reads_checked (reads_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_n <= 0;
    end else if (idle_n >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_n);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_n <= idle_n + 1;
    end
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  task automatic push_item(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent_n++;
  endtask

  task automatic offer(input logic [CMD_W-1:0] cmd, input int sample, input int sel);
    item_t it;
    it.command      = cmd;
    it.sample_value = SAMPLE_BITS'(sample);
    it.bin_select   = SEL_W'(sel);
    if (!calm && $urandom_range(0, 99) < 27) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input int data);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= DATA_W'(data);
    @(posedge clk);
  endtask

  task automatic configure(input int low, input int scale, input int count);
    write_reg(REG_LOW_SAMPLE, low & 16'hFFFF);
    write_reg(REG_BIN_SCALE, scale);
    write_reg(REG_BIN_COUNT, count);
    write_en   <= 1'b0;
    cur_low    = low;
    cur_scale  = scale & 17'h1FFFF;
    cur_count  = count & 11'h7FF;
    settings_n++;
  endtask

  function automatic int bins_used();
    return (cur_count < MAX_BINS) ? cur_count : MAX_BINS;
  endfunction

  function automatic int pick_sample();
    int span;
    int v;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom_range(0, 65535) - 32768;
    if (roll < 25) begin
      v = cur_low - $urandom_range(1, 3);
      return (v < -32768) ? -32768 : v;
    end
    if (cur_scale == 0) span = 4;
    else span = (bins_used() * 65536) / cur_scale + 2;
    if (span > 65535) span = 65535;
    v = cur_low + $urandom_range(0, span);
    return (v > 32767) ? 32767 : v;
  endfunction

  function automatic int pick_bin();
    if (bins_used() > 0 && $urandom_range(0, 99) < 70) return $urandom_range(0, bins_used() - 1);
    return $urandom_range(0, 1023);
  endfunction

  task automatic random_item();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) offer(CMD_ADD, pick_sample(), $urandom_range(0, 1023));
    else if (roll < 80) offer(CMD_READ, $urandom_range(0, 65535) - 32768, pick_bin());
    else if (roll < 97) offer(CMD_CLEAR, $urandom_range(0, 65535) - 32768, pick_bin());
    else offer(CMD_UNUSED, pick_sample(), pick_bin());
  endtask

  task automatic random_setting(input int phase);
    int low;
    int scale;
    int count;
    int roll;
    roll = $urandom_range(0, 9);
    low  = (roll == 0) ? -32768 : (roll == 1) ? 32767 - $urandom_range(0, 40)
         : $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 9))
      0:       scale = 65536;
      1:       scale = 1;
      2:       scale = $urandom_range(0, 131071);
      3:       scale = 0;
      default: scale = $urandom_range(1, 65536);
    endcase
    case ($urandom_range(0, 7))
      0:       count = 1;
      1:       count = 1024;
      2:       count = $urandom_range(0, 2047);
      default: count = $urandom_range(1, 1024);
    endcase
    if (phase == 0) begin
      scale = 65536;
      count = 1;
    end else if (phase == 1) begin
      scale = 1;
      count = 1024;
    end
    configure(low, scale, count);
  endtask

  initial begin
    rst         <= 1'b1;
    write_en    <= 1'b0;
    write_index <= '0;
    write_data  <= '0;
    item_valid  <= 1'b0;
    item        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // straddles, last-bin straddle, below low edge, top edge dropped
    configure(0, 40000, 4);
    offer(CMD_ADD, -1, 0);
    offer(CMD_ADD, 0, 0);
    offer(CMD_ADD, 1, 0);
    offer(CMD_ADD, 6, 0);
    offer(CMD_ADD, 7, 0);
    offer(CMD_ADD, 32767, 1023);
    offer(CMD_ADD, -32768, 0);
    offer(CMD_READ, 0, 0);
    offer(CMD_READ, 0, 1);
    offer(CMD_CLEAR, 0, 3);
    offer(CMD_READ, 0, 3);
    offer(CMD_UNUSED, 0, 0);
    offer(CMD_READ, 0, 1023);
    drain();

    // zero bins, zero scale, oversize count, unused register index
    write_reg(REG_UNUSED, 17'h1FFFF);
    configure(32767, 0, 0);
    offer(CMD_ADD, 32767, 0);
    offer(CMD_READ, 0, 1);
    drain();
    configure(32767, 0, 2047);
    offer(CMD_ADD, 32767, 0);
    offer(CMD_ADD, 32766, 0);
    offer(CMD_CLEAR, 0, 0);
    drain();

    configure(-32768, 65536, 1024);
    offer(CMD_ADD, -32768, 0);
    offer(CMD_ADD, 32767, 0);
    offer(CMD_ADD, -31745, 0);
    offer(CMD_READ, -1, 1023);
    offer(CMD_CLEAR, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      random_setting(p);
      calm = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == 20) hold_req <= 1'b1;
        if (p == 6 && k == 75) drain();
        random_item();
      end
    end
    calm = 1'b0;
    drain();

    $display("Run covered %0d transactions under %0d register settings, %0d reads checked",
             sent_n, settings_n, reads_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/swh_pkg.sv
rtl/swh_bin_ram.sv
rtl/swh_ctrl.sv
rtl/split_weight_histogram_top.sv
verif/split_weight_histogram_checker.sv
verif/split_weight_histogram_top_test.sv
